// ===== rtl/imm_pkg.sv =====
// Package for the integer matrix multiplier: shared types and constants.
// No dependencies; every other file in rtl/ imports it.
`default_nettype none

package imm_pkg;

  // Width of an effective matrix dimension (holds up to thirty-one).
  localparam int DIM_W = 5;
  // Width of a store address as carried between front and back.
  localparam int ADDR_W = 8;
  // Width of a matrix element and of a product element.
  localparam int DATA_W = 32;
  // Width of a size register and of the configuration port.
  localparam int REG_W = 4;
  localparam int CFG_IDX_W = 2;
  // Width of the emitted row and column indices.
  localparam int IDX_W = 3;

  // Configuration register indices.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B     = 2'd2;

  // Store write request from the front to the back.
  typedef struct packed {
    logic              we;
    logic              sel_b;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } wr_req_t;

  // One multiplication run, with its effective dimensions.
  typedef struct packed {
    logic [DIM_W-1:0] ra;
    logic [DIM_W-1:0] ni;
    logic [DIM_W-1:0] cb;
  } job_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/imm_front.sv =====
// Front end of the integer matrix multiplier: size registers, load counter,
// store write requests and run descriptors. Depends on imm_pkg.
`default_nettype none

module imm_front #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic                         busy,
  input  wire logic [imm_pkg::DATA_W-1:0]   element,
  input  wire logic                         cfg_write,
  input  wire logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [imm_pkg::REG_W-1:0]    cfg_data,
  output imm_pkg::wr_req_t                  wr,
  output logic                              push,
  output imm_pkg::job_t                     job
);
  import imm_pkg::*;

  localparam int SW = 2 * DIM_W + 1;
  localparam int LW = $clog2(2 * MAX_DIM * MAX_DIM + 1);

  logic [REG_W-1:0] rows_a, inner_size, cols_b;
  logic [LW-1:0]    load_count, load_count_next;

  logic [DIM_W-1:0] ra, ni, cb;
  logic [SW-1:0]    size_a, size_b, lc_ext, bi;
  logic             accept, in_a;

  // Zero counts as one, and values above the largest dimension are clamped.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [REG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (DIM_W'(v) > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  assign ra     = eff_dim(rows_a);
  assign ni     = eff_dim(inner_size);
  assign cb     = eff_dim(cols_b);
  assign size_a = SW'(ra * ni);
  assign size_b = SW'(ni * cb);
  assign lc_ext = SW'(load_count);
  assign bi     = lc_ext - size_a;
  assign accept = start && !busy;
  assign in_a   = lc_ext < size_a;

  always_comb begin
    wr.we           = accept;
    wr.sel_b        = !in_a;
    wr.addr         = in_a ? lc_ext[ADDR_W-1:0] : bi[ADDR_W-1:0];
    wr.data         = element;
    push            = 1'b0;
    load_count_next = load_count;
    if (accept) begin
      if (!in_a && (bi + SW'(1) == size_b)) begin
        push            = 1'b1;
        load_count_next = '0;
      end else begin
        load_count_next = load_count + LW'(1);
      end
    end
  end

  assign job.ra = ra;
  assign job.ni = ni;
  assign job.cb = cb;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= REG_W'(8);
      inner_size <= REG_W'(8);
      cols_b     <= REG_W'(8);
      load_count <= '0;
    end else if (cfg_write) begin
      // A size change abandons any partial load.
      unique case (cfg_index)
        REG_ROWS_A: begin
          rows_a     <= cfg_data;
          load_count <= '0;
        end
        REG_INNER_SIZE: begin
          inner_size <= cfg_data;
          load_count <= '0;
        end
        REG_COLS_B: begin
          cols_b     <= cfg_data;
          load_count <= '0;
        end
        default: begin
          load_count <= load_count_next;
        end
      endcase
    end else begin
      load_count <= load_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/imm_queue.sv =====
// Two-entry queue of run descriptors between the front and back ends.
// Depends on imm_pkg.
`default_nettype none

module imm_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire imm_pkg::job_t push_job,
  input  wire logic         pop,
  output logic              not_empty,
  output logic              full,
  output imm_pkg::job_t     head
);
  import imm_pkg::*;

  job_t       entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign not_empty = count != 2'd0;
  assign full      = count == 2'd2;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && not_empty) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/imm_back.sv =====
// Back end of the integer matrix multiplier: the A and B stores, the index
// sequencer and the multiply-accumulate pipeline. Depends on imm_pkg.
`default_nettype none

module imm_back #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire imm_pkg::wr_req_t           wr,
  input  wire logic                       job_valid,
  input  wire imm_pkg::job_t              job,
  output logic                            pop,
  output logic                            active,
  output logic                            result_valid,
  output logic [imm_pkg::DATA_W-1:0]      product,
  output logic [imm_pkg::IDX_W-1:0]       row_index,
  output logic [imm_pkg::IDX_W-1:0]       col_index,
  output logic                            last_of_run
);
  import imm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem_a [DEPTH];
  logic [DATA_W-1:0] mem_b [DEPTH];

  back_state_t      state, state_next;
  logic [DIM_W-1:0] ra, ni, cb, ra_next, ni_next, cb_next;
  logic [DIM_W-1:0] i_cnt, j_cnt, k_cnt, i_next, j_next, k_next;
  logic [AW-1:0]    a_row, b_ptr, a_row_next, b_ptr_next;

  logic             iss_valid, iss_first, iss_lastk, iss_last;
  logic [AW-1:0]    iss_a_addr;

  logic              s1_valid, s1_first, s1_lastk, s1_last;
  logic [IDX_W-1:0]  s1_i, s1_j;
  logic [DATA_W-1:0] a_q, b_q;

  logic              s2_valid, s2_first, s2_lastk, s2_last;
  logic [IDX_W-1:0]  s2_i, s2_j;
  logic [DATA_W-1:0] s2_prod;

  logic [DATA_W-1:0] acc, acc_sum;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      if (wr.sel_b) begin
        mem_b[wr.addr[AW-1:0]] <= wr.data;
      end else begin
        mem_a[wr.addr[AW-1:0]] <= wr.data;
      end
    end
  end

  assign iss_a_addr = a_row + AW'(k_cnt);

  always_ff @(posedge clk) begin
    a_q <= mem_a[iss_a_addr];
    b_q <= mem_b[b_ptr];
  end

  // Walks i, j, k of the product in row-major order, one term per cycle.
  always_comb begin
    state_next = state;
    ra_next    = ra;
    ni_next    = ni;
    cb_next    = cb;
    i_next     = i_cnt;
    j_next     = j_cnt;
    k_next     = k_cnt;
    a_row_next = a_row;
    b_ptr_next = b_ptr;
    pop        = 1'b0;
    iss_valid  = 1'b0;
    iss_first  = k_cnt == '0;
    iss_lastk  = k_cnt == ni - DIM_W'(1);
    iss_last   = iss_lastk && (j_cnt == cb - DIM_W'(1)) && (i_cnt == ra - DIM_W'(1));
    unique case (state)
      BK_IDLE: begin
        if (job_valid) begin
          pop        = 1'b1;
          ra_next    = job.ra;
          ni_next    = job.ni;
          cb_next    = job.cb;
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
          a_row_next = '0;
          b_ptr_next = '0;
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        iss_valid = 1'b1;
        if (iss_lastk) begin
          k_next = '0;
          if (j_cnt == cb - DIM_W'(1)) begin
            j_next     = '0;
            i_next     = i_cnt + DIM_W'(1);
            a_row_next = a_row + AW'(ni);
            b_ptr_next = '0;
            if (i_cnt == ra - DIM_W'(1)) begin
              state_next = BK_IDLE;
            end
          end else begin
            j_next     = j_cnt + DIM_W'(1);
            b_ptr_next = AW'(j_cnt + DIM_W'(1));
          end
        end else begin
          k_next     = k_cnt + DIM_W'(1);
          b_ptr_next = b_ptr + AW'(cb);
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    ra    <= ra_next;
    ni    <= ni_next;
    cb    <= cb_next;
    i_cnt <= i_next;
    j_cnt <= j_next;
    k_cnt <= k_next;
    a_row <= a_row_next;
    b_ptr <= b_ptr_next;
  end

  assign acc_sum = s2_first ? s2_prod : acc + s2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= iss_valid;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid && s2_lastk;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= iss_first;
    s1_lastk <= iss_lastk;
    s1_last  <= iss_last;
    s1_i     <= i_cnt[IDX_W-1:0];
    s1_j     <= j_cnt[IDX_W-1:0];
    s2_first <= s1_first;
    s2_lastk <= s1_lastk;
    s2_last  <= s1_last;
    s2_i     <= s1_i;
    s2_j     <= s1_j;
    s2_prod  <= DATA_W'(a_q * b_q);
    if (s2_valid) begin
      acc <= acc_sum;
    end
    product     <= acc_sum;
    row_index   <= s2_i;
    col_index   <= s2_j;
    last_of_run <= s2_valid && s2_last;
  end

  assign active = (state == BK_RUN) || s1_valid || s2_valid;

endmodule

`default_nettype wire

// ===== rtl/integer_matrix_multiply.sv =====
// Top level of the integer matrix multiplier: front end, run queue and
// back end. Depends on imm_pkg, imm_front, imm_queue and imm_back.
`default_nettype none

// Channel    Ports                                           Transfer
// ---------  ----------------------------------------------  ---------------------------
// input      start, busy, element                            edge with start & !busy
// result     result_valid, product, row_index, col_index,    every edge with result_valid
//            last_of_run
// config     cfg_write, cfg_index, cfg_data                  every edge with cfg_write
//
// A is loaded row-major, then B. The transfer carrying the last element of B
// starts a run; its results are shown in row-major order and come from the
// single shared multiply-accumulate, which takes one term per cycle from the
// two stores. busy rises in the cycle after that transfer and falls in the
// cycle in which the final result is shown.
// Reset is synchronous and active high; it sets all three sizes to eight and
// clears the load count. The stores are not cleared. The receiver of results
// cannot stall the block; each result is shown for exactly one cycle.

module integer_matrix_multiply #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [imm_pkg::DATA_W-1:0]    element,
  input  wire logic                          cfg_write,
  input  wire logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [imm_pkg::REG_W-1:0]     cfg_data,
  output logic                               result_valid,
  output logic [imm_pkg::DATA_W-1:0]         product,
  output logic [imm_pkg::IDX_W-1:0]          row_index,
  output logic [imm_pkg::IDX_W-1:0]          col_index,
  output logic                               last_of_run
);
  import imm_pkg::*;

  wr_req_t wr;
  job_t    push_job, head_job;
  logic    push, pop, q_not_empty, q_full, back_active;

  // The front end takes element transfers and turns the final one of a
  // load into a run descriptor.
  imm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .element   (element),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr        (wr),
    .push      (push),
    .job       (push_job)
  );

  imm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .not_empty (q_not_empty),
    .full      (q_full),
    .head      (head_job)
  );

  // The back end owns the stores and forms the dot products.
  imm_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .job_valid    (q_not_empty),
    .job          (head_job),
    .pop          (pop),
    .active       (back_active),
    .result_valid (result_valid),
    .product      (product),
    .row_index    (row_index),
    .col_index    (col_index),
    .last_of_run  (last_of_run)
  );

  // New elements would overwrite the stores that a run is still reading,
  // so loading waits until the queue is empty and the back end has drained.
  assign busy = q_not_empty || back_active;

  // A run descriptor must never find the queue full.
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    !(push && q_full))
    else $error("run queue overflow");

  // Every result but the final one of a run is shown while busy is high.
  a_busy_in_run : assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_of_run) |-> busy)
    else $error("busy dropped before the end of a run");

  // The final-result flag only accompanies a result.
  a_last_valid : assert property (@(posedge clk) disable iff (rst)
    last_of_run |-> result_valid)
    else $error("last_of_run without a result");

  // A queued run descriptor is visible, with busy high, in the cycle after it is pushed.
  a_run_starts : assert property (@(posedge clk) disable iff (rst)
    push |=> (q_not_empty && busy))
    else $error("queued run not visible");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for integer_matrix_multiply: directed table, then paced random runs.
// Depends on imm_pkg and the RTL in rtl/; the product predictor is held in this file.

module tb;
  import imm_pkg::*;

  localparam int MAX_DIM        = 8;
  localparam int STORE_DEPTH    = MAX_DIM * MAX_DIM;
  // Random elements on top of the directed table, about 410 transfers in all.
  localparam int RANDOM_ITEMS   = 385;
  // Quiet cycles before a register write, so that a run still in flight has finished.
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 20;
  // Cycles with neither an element transfer nor a result before the run is abandoned.
  // The longest honest quiet stretch is a settle pause plus a sender gap plus the
  // start-up latency of a run.
  localparam int WATCHDOG_LIMIT = 2000;
  // An index past the end of the register list; the block must ignore such a write.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // One product element as the block presents it.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
  } prod_item_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_ELEMENT
  } row_kind_t;

  // One line of the directed table. Where known is set, the product of the run
  // is a single element whose value is typed in and replaces the prediction.
  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    value;
    logic                 known;
    prod_item_t           want;
  } plan_row_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [DATA_W-1:0]    element;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;
  logic                 result_valid;
  logic [DATA_W-1:0]    product;
  logic [IDX_W-1:0]     row_index;
  logic [IDX_W-1:0]     col_index;
  logic                 last_of_run;

  integer_matrix_multiply #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .element(element),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .product(product),
    .row_index(row_index),
    .col_index(col_index),
    .last_of_run(last_of_run)
  );

  // Predictor state: the two element stores, the count of elements taken in the
  // current load and the three size registers as last written.
  logic [DATA_W-1:0] a_store [STORE_DEPTH];
  logic [DATA_W-1:0] b_store [STORE_DEPTH];
  int unsigned       fill_count;
  logic [REG_W-1:0]  size_rows;
  logic [REG_W-1:0]  size_inner;
  logic [REG_W-1:0]  size_cols;

  // Products made by the latest element, and the queue of products still owed by the block.
  prod_item_t fresh_products[$];
  prod_item_t expected_products[$];

  int mismatch_count;
  int transfer_count;
  int product_count;
  int write_count;
  int idle_cycles;
  int burst_left;

  plan_row_t plan[$];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // A size register of zero is taken as one, and anything above the largest
  // dimension is taken as that dimension.
  function automatic int unsigned clamp_size(logic [REG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  // Takes one element into the predictor. A fills first, then B; the element
  // that completes B yields the whole product in row-major order and the load
  // starts again with A. Sums wrap at 32 bits, which is simply the width of acc.
  function automatic void load_element(logic [DATA_W-1:0] v);
    int unsigned ra, ni, cb, size_a, size_b, bi;
    int          i, j, k;
    logic [DATA_W-1:0] acc;
    prod_item_t  item;
    ra = clamp_size(size_rows);
    ni = clamp_size(size_inner);
    cb = clamp_size(size_cols);
    size_a = ra * ni;
    size_b = ni * cb;
    fresh_products.delete();
    if (fill_count < size_a) begin
      a_store[fill_count] = v;
      fill_count++;
      return;
    end
    bi = fill_count - size_a;
    b_store[bi % STORE_DEPTH] = v;
    fill_count++;
    if (bi + 1 < size_b) return;
    fill_count = 0;
    for (i = 0; i < ra; i++) begin
      for (j = 0; j < cb; j++) begin
        acc = '0;
        for (k = 0; k < ni; k++) begin
          acc = acc + a_store[i * ni + k] * b_store[k * cb + j];
        end
        item.value = acc;
        item.row   = i[IDX_W-1:0];
        item.col   = j[IDX_W-1:0];
        item.last  = (i == ra - 1) && (j == cb - 1);
        fresh_products.push_back(item);
      end
    end
  endfunction

  // Half full-range random values, with the two extremes and small signed
  // numbers mixed in so that wrapping and sign handling are both exercised.
  function automatic logic [DATA_W-1:0] pick_element();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // Sizes are mostly small to keep runs short; zero and values above the limit
  // appear now and then so that both clamps keep being used.
  function automatic logic [REG_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return REG_W'($urandom_range(MAX_DIM + 1, 15));
      default: return REG_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic plan_row_t write_row(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
    plan_row_t r;
    r = '0;
    r.kind  = ROW_WRITE;
    r.index = idx;
    r.value = DATA_W'(data);
    return r;
  endfunction

  // A known value always belongs to a one-by-one product: row and column zero, last set.
  function automatic plan_row_t element_row(logic [DATA_W-1:0] v, logic known,
                                            logic [DATA_W-1:0] want_value);
    plan_row_t r;
    r = '0;
    r.kind       = ROW_ELEMENT;
    r.value      = v;
    r.known      = known;
    r.want.value = want_value;
    r.want.last  = 1'b1;
    return r;
  endfunction

  // Drops start at the next falling edge; the element bus carries noise while idle.
  task automatic release_start();
    @(negedge clk);
    start   = 1'b0;
    element = $urandom;
  endtask

  task automatic hold_off(int cycles);
    release_start();
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Waits until every owed product has arrived, then waits out a further quiet pause.
  task automatic settle();
    release_start();
    while (expected_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
    settle();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    // Any write to a real register abandons a partial load; other indexes do nothing.
    case (idx)
      REG_ROWS_A: begin
        size_rows  = data;
        fill_count = 0;
      end
      REG_INNER_SIZE: begin
        size_inner = data;
        fill_count = 0;
      end
      REG_COLS_B: begin
        size_cols  = data;
        fill_count = 0;
      end
      default: ;
    endcase
    write_count++;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Presents one element and holds it until the transfer happens. start stays
  // high afterwards, so back-to-back calls give unbroken transfers while busy stays low.
  task automatic send_element(logic [DATA_W-1:0] v, logic known, prod_item_t want);
    @(negedge clk);
    start   = 1'b1;
    element = v;
    do @(posedge clk); while (busy);
    transfer_count++;
    load_element(v);
    if (known) begin
      expected_products.push_back(want);
    end else begin
      foreach (fresh_products[n]) expected_products.push_back(fresh_products[n]);
    end
  endtask

  // Sender pacing: bursts of random length, separated by random gaps.
  task automatic pace();
    if (burst_left == 0) begin
      hold_off($urandom_range(1, 12));
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  // Result checker: every strobe must match the oldest owed product field by field.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      product_count++;
      if (expected_products.size() == 0) begin
        $display("%0t: unexpected product %h at row %0d column %0d", $time,
                 product, row_index, col_index);
        mismatch_count++;
      end else begin
        if (product !== expected_products[0].value) begin
          $display("%0t: product mismatch: expected %h, actual %h", $time,
                   expected_products[0].value, product);
          mismatch_count++;
        end
        if (row_index !== expected_products[0].row) begin
          $display("%0t: row_index mismatch: expected %0d, actual %0d", $time,
                   expected_products[0].row, row_index);
          mismatch_count++;
        end
        if (col_index !== expected_products[0].col) begin
          $display("%0t: col_index mismatch: expected %0d, actual %0d", $time,
                   expected_products[0].col, col_index);
          mismatch_count++;
        end
        if (last_of_run !== expected_products[0].last) begin
          $display("%0t: last_of_run mismatch: expected %b, actual %b", $time,
                   expected_products[0].last, last_of_run);
          mismatch_count++;
        end
        void'(expected_products.pop_front());
      end
    end
  end

  // Watchdog: the run is abandoned when nothing at all is transferred for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int random_items;
    int phase;
    int runs;
    int run_len;
    int mask;
    rst          = 1'b1;
    start        = 1'b0;
    element      = '0;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    burst_left   = 0;
    transfer_count = 0;
    write_count    = 0;
    random_items   = 0;
    phase          = 0;
    fill_count     = 0;
    size_rows      = 4'd8;
    size_inner     = 4'd8;
    size_cols      = 4'd8;
    foreach (a_store[n]) a_store[n] = '0;
    foreach (b_store[n]) b_store[n] = '0;

    // Directed table. The first runs are one-by-one products of the extreme
    // values, whose wrapped results can be read off directly.
    plan.push_back(write_row(REG_ROWS_A, 4'd1));
    plan.push_back(write_row(REG_INNER_SIZE, 4'd1));
    plan.push_back(write_row(REG_COLS_B, 4'd1));
    plan.push_back(element_row(32'h7FFF_FFFF, 1'b0, '0));
    plan.push_back(element_row(32'h7FFF_FFFF, 1'b1, 32'h0000_0001));
    plan.push_back(element_row(32'h8000_0000, 1'b0, '0));
    plan.push_back(element_row(32'hFFFF_FFFF, 1'b1, 32'h8000_0000));
    plan.push_back(element_row(32'h0000_0000, 1'b0, '0));
    plan.push_back(element_row(32'hFFFF_FFFF, 1'b1, 32'h0000_0000));
    // An inner size of zero behaves as one.
    plan.push_back(write_row(REG_INNER_SIZE, 4'd0));
    plan.push_back(element_row(32'd3, 1'b0, '0));
    plan.push_back(element_row(32'hFFFF_FFFB, 1'b1, 32'hFFFF_FFF1));
    // A write to an index past the list, in the middle of a load, leaves the load intact.
    plan.push_back(element_row(32'd7, 1'b0, '0));
    plan.push_back(write_row(REG_UNUSED, 4'd5));
    plan.push_back(element_row(32'd6, 1'b1, 32'd42));
    // A real register write after A is complete drops it; A is loaded again from the start.
    plan.push_back(write_row(REG_INNER_SIZE, 4'd2));
    plan.push_back(element_row(32'd1, 1'b0, '0));
    plan.push_back(element_row(32'd2, 1'b0, '0));
    plan.push_back(write_row(REG_COLS_B, 4'd1));
    plan.push_back(element_row(32'd4, 1'b0, '0));
    plan.push_back(element_row(32'd5, 1'b0, '0));
    plan.push_back(element_row(32'd6, 1'b0, '0));
    plan.push_back(element_row(32'd7, 1'b1, 32'd59));
    // Rows above the limit are clamped to eight: an eight-by-one column of products.
    plan.push_back(write_row(REG_INNER_SIZE, 4'd1));
    plan.push_back(write_row(REG_ROWS_A, 4'd15));
    plan.push_back(element_row(32'd1, 1'b0, '0));
    plan.push_back(element_row(32'hFFFF_FFFF, 1'b0, '0));
    plan.push_back(element_row(32'h7FFF_FFFF, 1'b0, '0));
    plan.push_back(element_row(32'h8000_0000, 1'b0, '0));
    plan.push_back(element_row(32'd2, 1'b0, '0));
    plan.push_back(element_row(32'h0001_0000, 1'b0, '0));
    plan.push_back(element_row(32'h5555_5555, 1'b0, '0));
    plan.push_back(element_row(32'hAAAA_AAAA, 1'b0, '0));
    plan.push_back(element_row(32'hFFFF_FFFE, 1'b0, '0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) begin
        write_register(plan[r].index, plan[r].value[REG_W-1:0]);
      end else begin
        send_element(plan[r].value, plan[r].known, plan[r].want);
      end
    end

    // Random phases: new sizes, a few complete runs with random content, and
    // now and then a partial load that the next register write throws away.
    // One early phase uses the full eight-by-eight size.
    while (random_items < RANDOM_ITEMS) begin
      if (phase == 2) begin
        write_register(REG_ROWS_A, 4'd8);
        write_register(REG_INNER_SIZE, 4'd15);
        write_register(REG_COLS_B, 4'd8);
        runs = 1;
      end else begin
        if ($urandom_range(0, 3) == 0) write_register(REG_UNUSED, REG_W'($urandom));
        mask = $urandom_range(1, 7);
        if (mask[0]) write_register(REG_ROWS_A, pick_size());
        if (mask[1]) write_register(REG_INNER_SIZE, pick_size());
        if (mask[2]) write_register(REG_COLS_B, pick_size());
        runs = $urandom_range(1, 3);
      end
      run_len = clamp_size(size_inner) * (clamp_size(size_rows) + clamp_size(size_cols));
      repeat (runs) begin
        repeat (run_len) begin
          if (random_items < RANDOM_ITEMS) begin
            pace();
            send_element(pick_element(), 1'b0, '0);
            random_items++;
          end
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, run_len - 1)) begin
          if (random_items < RANDOM_ITEMS) begin
            pace();
            send_element(pick_element(), 1'b0, '0);
            random_items++;
          end
        end
      end
      phase++;
    end

    release_start();
    while (expected_products.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d element transfers and %0d register writes over %0d random phases,",
             transfer_count, write_count, phase);
    $display("checking %0d product elements; sizes ranged from one to eight, clamps included.",
             product_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/imm_pkg.sv
rtl/imm_front.sv
rtl/imm_queue.sv
rtl/imm_back.sv
rtl/integer_matrix_multiply.sv
bench/tb.sv
